[hdl/wfd_pkg.sv]
`default_nettype none

package wfd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_DATA
  } phase_t;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [2:0] KIND_TEXT   = 3'd0;
  localparam logic [2:0] KIND_BINARY = 3'd1;
  localparam logic [2:0] KIND_CONT   = 3'd2;
  localparam logic [2:0] KIND_PONG   = 3'd3;
  localparam logic [2:0] KIND_CLOSE  = 3'd4;

  localparam logic [6:0]  LEN_EXT16 = 7'd126;
  localparam logic [6:0]  LEN_EXT64 = 7'd127;
  localparam logic [3:0]  EXT16_BYTES = 4'd2;
  localparam logic [3:0]  EXT64_BYTES = 4'd8;
  localparam logic [3:0]  MASK_BYTES  = 4'd4;
  localparam logic [15:0] CLOSE_DEFAULT = 16'd1000;

  typedef struct packed {
    logic       keep;
    logic [2:0] kind;
  } kind_info_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic [2:0]  kind;
    logic        frame_end;
    logic        message_end;
    logic        message_is_text;
    logic        close_event;
    logic [15:0] close_code;
  } res_t;

  // Pong and reserved opcodes are consumed without producing results.
  function automatic kind_info_t kind_of(input logic [3:0] op);
    kind_info_t ki;
    ki.keep = 1'b1;
    ki.kind = KIND_TEXT;
    case (op)
      OP_CONT:   ki.kind = KIND_CONT;
      OP_TEXT:   ki.kind = KIND_TEXT;
      OP_BINARY: ki.kind = KIND_BINARY;
      OP_CLOSE:  ki.kind = KIND_CLOSE;
      OP_PING:   ki.kind = KIND_PONG;
      default:   ki.keep = 1'b0;
    endcase
    return ki;
  endfunction

endpackage

`default_nettype wire

[hdl/websocket_frame_deframer_core.sv]
// Receive-side frame parser for a message-oriented socket link.
// Input channel rx_valid/rx_ready/rx_byte carries the raw stream, one byte
// per transaction. Output channel res_valid/res_ready carries at most one
// result per input byte: an unmasked payload byte tagged with its kind, or
// an empty frame-end marker, with frame_end, message_end, message_is_text,
// close_event and close_code alongside.
// Header, extended length and mask key bytes normally give no result.
// A byte's result is registered: the byte is first held in the input
// register, then parsed into the output register. Throughput is one byte
// per cycle while the output register can load, set by the single parse
// step between the input register and the result register.
// Reset clears the parser to expect a new frame header and empties both
// registers. When the receiver stalls, one result waits in the output
// register and one byte in the input register, then rx_ready drops.
// After a close frame completes, all further bytes are accepted and
// discarded until reset.
`default_nettype none

module websocket_frame_deframer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rx_valid,
  output logic             rx_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [7:0]       payload_byte,
  output logic             has_byte,
  output logic [2:0]       kind,
  output logic             frame_end,
  output logic             message_end,
  output logic             message_is_text,
  output logic             close_event,
  output logic [15:0]      close_code
);

  import wfd_pkg::*;

  logic       can_load;
  logic       take;
  logic [7:0] rx_data;
  logic       res_fire;
  res_t       res_next;
  res_t       res_q;

  wfd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_byte  (rx_byte),
    .advance  (can_load),
    .take     (take),
    .rx_data  (rx_data)
  );

  wfd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .rx_data  (rx_data),
    .res_fire (res_fire),
    .res      (res_next)
  );

  wfd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_fire),
    .res_in    (res_next),
    .can_load  (can_load),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_q     (res_q)
  );

  assign payload_byte    = res_q.payload_byte;
  assign has_byte        = res_q.has_byte;
  assign kind            = res_q.kind;
  assign frame_end       = res_q.frame_end;
  assign message_end     = res_q.message_end;
  assign message_is_text = res_q.message_is_text;
  assign close_event     = res_q.close_event;
  assign close_code      = res_q.close_code;

endmodule

`default_nettype wire

[hdl/wfd_in_stage.sv]
`default_nettype none

module wfd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  output logic            rx_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       advance,
  output logic            take,
  output logic [7:0]      rx_data
);

  logic full;
  logic full_next;

  assign take     = full && advance;
  assign rx_ready = !full || advance;

  always_comb begin
    full_next = full;
    if (rx_valid && rx_ready) begin
      full_next = 1'b1;
    end else if (take) begin
      full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && rx_ready) begin
      rx_data <= rx_byte;
    end
  end

endmodule

`default_nettype wire

[hdl/wfd_parser.sv]
`default_nettype none

module wfd_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] rx_data,
  output logic            res_fire,
  output wfd_pkg::res_t   res
);

  import wfd_pkg::*;

  phase_t      phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic [3:0]  ext_left, ext_left_next;
  logic [63:0] payload_left, payload_left_next;
  logic [1:0]  idx, idx_next;
  logic        ge2, ge2_next;
  logic [31:0] mask_key, mask_key_next;
  logic [15:0] close_acc, close_acc_next;
  logic        msg_open, msg_open_next;
  logic        msg_text, msg_text_next;
  logic        link_closed, link_closed_next;

  logic        active;
  logic [6:0]  len7;
  logic        len_long;
  logic [3:0]  ext_dec;
  logic [63:0] pl_shift;
  logic [63:0] pl_len;
  logic [63:0] pl_hdr;
  logic        mask_now;
  logic        len_done;
  logic        hdr_done;
  logic        deliver;
  logic        last;
  logic [7:0]  key_byte;
  logic [7:0]  data_val;
  logic        close_status;
  logic        has;
  kind_info_t  ki;

  // Shared decode of the byte against the current parse position.
  always_comb begin
    active   = take && !link_closed;
    len7     = rx_data[6:0];
    len_long = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
    ext_dec  = ext_left - 4'd1;
    pl_shift = {payload_left[55:0], rx_data};
    len_done = 1'b0;
    pl_len   = pl_shift;
    mask_now = masked;
    case (phase)
      PH_HDR1: begin
        len_done = !len_long;
        pl_len   = {57'd0, len7};
        mask_now = rx_data[7];
      end
      PH_EXT: begin
        len_done = (ext_dec == 4'd0);
      end
      default: begin
      end
    endcase
    hdr_done = (len_done && !mask_now) || ((phase == PH_MASK) && (ext_dec == 4'd0));
    pl_hdr   = (phase == PH_MASK) ? payload_left : pl_len;
    deliver  = (hdr_done && (pl_hdr == 64'd0)) || (phase == PH_DATA);
    last     = (phase == PH_DATA) ? (payload_left == 64'd1) : 1'b1;
    case (idx)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    data_val     = masked ? (rx_data ^ key_byte) : rx_data;
    close_status = (phase == PH_DATA) && (opcode == OP_CLOSE) && !ge2;
    has          = (phase == PH_DATA) && !close_status;
    ki           = kind_of(opcode);
  end

  // Next parse phase.
  always_comb begin
    phase_next = phase;
    if (active) begin
      case (phase)
        PH_HDR0: phase_next = PH_HDR1;
        PH_HDR1: begin
          if (len_long) begin
            phase_next = PH_EXT;
          end else if (mask_now) begin
            phase_next = PH_MASK;
          end else if (pl_hdr == 64'd0) begin
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_EXT: begin
          if (ext_dec != 4'd0) begin
            phase_next = PH_EXT;
          end else if (masked) begin
            phase_next = PH_MASK;
          end else if (pl_hdr == 64'd0) begin
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_MASK: begin
          if (ext_dec != 4'd0) begin
            phase_next = PH_MASK;
          end else if (pl_hdr == 64'd0) begin
            phase_next = PH_HDR0;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: phase_next = last ? PH_HDR0 : PH_DATA;
        default: phase_next = PH_HDR0;
      endcase
    end
  end

  // Frame and message registers.
  always_comb begin
    fin_next          = fin;
    opcode_next       = opcode;
    masked_next       = masked;
    ext_left_next     = ext_left;
    payload_left_next = payload_left;
    idx_next          = idx;
    ge2_next          = ge2;
    mask_key_next     = mask_key;
    close_acc_next    = close_acc;
    msg_open_next     = msg_open;
    msg_text_next     = msg_text;
    link_closed_next  = link_closed;
    if (active) begin
      case (phase)
        PH_HDR0: begin
          fin_next          = rx_data[7];
          opcode_next       = rx_data[3:0];
          payload_left_next = 64'd0;
          idx_next          = 2'd0;
          ge2_next          = 1'b0;
          mask_key_next     = 32'd0;
          close_acc_next    = 16'd0;
          ext_left_next     = 4'd0;
          if ((rx_data[3:0] == OP_TEXT) || (rx_data[3:0] == OP_BINARY)) begin
            msg_open_next = 1'b1;
            msg_text_next = (rx_data[3:0] == OP_TEXT);
          end
        end
        PH_HDR1: begin
          masked_next = rx_data[7];
          if (len_long) begin
            ext_left_next     = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
            payload_left_next = 64'd0;
          end else begin
            payload_left_next = pl_len;
            if (rx_data[7]) begin
              ext_left_next = MASK_BYTES;
            end
          end
        end
        PH_EXT: begin
          payload_left_next = pl_shift;
          ext_left_next     = ((ext_dec == 4'd0) && masked) ? MASK_BYTES : ext_dec;
        end
        PH_MASK: begin
          mask_key_next = {mask_key[23:0], rx_data};
          ext_left_next = ext_dec;
        end
        PH_DATA: begin
          if (close_status) begin
            close_acc_next = {close_acc[7:0], data_val};
          end
          idx_next          = idx + 2'd1;
          ge2_next          = ge2 || (idx != 2'd0);
          payload_left_next = payload_left - 64'd1;
        end
        default: begin
        end
      endcase
      if (deliver && ki.keep && last) begin
        if (fin && ((ki.kind == KIND_TEXT) || (ki.kind == KIND_BINARY) ||
                    (ki.kind == KIND_CONT))) begin
          msg_open_next = 1'b0;
        end
        if (ki.kind == KIND_CLOSE) begin
          link_closed_next = 1'b1;
        end
      end
    end
  end

  // Result for this byte.
  always_comb begin
    res_fire = active && deliver && ki.keep &&
               !((ki.kind == KIND_CLOSE) && !has && !last);
    res.payload_byte = has ? data_val : 8'd0;
    res.has_byte     = has;
    res.kind         = ki.kind;
    res.frame_end    = last;
    case (ki.kind)
      KIND_TEXT: res.message_is_text = 1'b1;
      KIND_CONT: res.message_is_text = msg_open && msg_text;
      default:   res.message_is_text = 1'b0;
    endcase
    res.message_end = last && fin &&
                      ((ki.kind == KIND_TEXT) || (ki.kind == KIND_BINARY) ||
                       ((ki.kind == KIND_CONT) && msg_open));
    res.close_event = last && (ki.kind == KIND_CLOSE);
    if (!res.close_event) begin
      res.close_code = 16'd0;
    end else if (ge2_next) begin
      res.close_code = close_acc_next;
    end else begin
      res.close_code = CLOSE_DEFAULT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      fin          <= 1'b0;
      opcode       <= 4'd0;
      masked       <= 1'b0;
      ext_left     <= 4'd0;
      payload_left <= 64'd0;
      idx          <= 2'd0;
      ge2          <= 1'b0;
      mask_key     <= 32'd0;
      close_acc    <= 16'd0;
      msg_open     <= 1'b0;
      msg_text     <= 1'b0;
      link_closed  <= 1'b0;
    end else begin
      phase        <= phase_next;
      fin          <= fin_next;
      opcode       <= opcode_next;
      masked       <= masked_next;
      ext_left     <= ext_left_next;
      payload_left <= payload_left_next;
      idx          <= idx_next;
      ge2          <= ge2_next;
      mask_key     <= mask_key_next;
      close_acc    <= close_acc_next;
      msg_open     <= msg_open_next;
      msg_text     <= msg_text_next;
      link_closed  <= link_closed_next;
    end
  end

endmodule

`default_nettype wire

[hdl/wfd_out_stage.sv]
`default_nettype none

module wfd_out_stage (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wfd_pkg::res_t      res_in,
  output logic               can_load,
  output logic               res_valid,
  input  wire logic          res_ready,
  output wfd_pkg::res_t      res_q
);

  import wfd_pkg::*;

  logic res_valid_next;

  assign can_load = !res_valid || res_ready;

  always_comb begin
    res_valid_next = res_valid;
    if (load) begin
      res_valid_next = 1'b1;
    end else if (res_ready) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res_in;
    end
  end

endmodule

`default_nettype wire

[hdl/wfd_checker.sv]
`default_nettype none

module wfd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [7:0]  payload_byte,
  input wire logic        has_byte,
  input wire logic [2:0]  kind,
  input wire logic        frame_end,
  input wire logic        message_end,
  input wire logic        close_event,
  input wire logic [15:0] close_code
);

  import wfd_pkg::*;

  // No result may be offered straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(payload_byte) && $stable(kind)
      && $stable(close_code))
    else $error("stalled result changed");

  // An empty result only ever marks the end of a frame.
  a_empty_is_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && !has_byte |-> frame_end && (payload_byte == 8'd0))
    else $error("empty result not at frame end");

  a_close_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && close_event |-> frame_end && (kind == KIND_CLOSE))
    else $error("close event outside close frame end");

  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && message_end |-> frame_end &&
      ((kind == KIND_TEXT) || (kind == KIND_BINARY) || (kind == KIND_CONT)))
    else $error("message end on a control frame");

endmodule

bind websocket_frame_deframer_core wfd_checker u_wfd_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res_valid),
  .res_ready    (res_ready),
  .payload_byte (payload_byte),
  .has_byte     (has_byte),
  .kind         (kind),
  .frame_end    (frame_end),
  .message_end  (message_end),
  .close_event  (close_event),
  .close_code   (close_code)
);

`default_nettype wire
